>>> src/code_comment_string_masker_assert.svh
// Assertion macros for the code comment and string masker.
`ifndef CODE_COMMENT_STRING_MASKER_ASSERT_SVH
`define CODE_COMMENT_STRING_MASKER_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define CCSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define CCSM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CCSM_ASSERT(lbl, prop, msg)
`define CCSM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/ccsm_pkg.sv
// Shared types and constants of the code comment and string masker.
package ccsm_pkg;

  localparam logic [7:0] CharStar      = 8'h2A;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharNone      = 8'h00;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic str;
    logic line;
    logic blk;
  } modes_t;

  typedef struct packed {
    logic       held_valid;
    modes_t     modes;
  } front_status_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_code;
    logic       eol;
  } result_t;

  // One queue entry holds every result that a single input transfer causes.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

>>> src/ccsm_in_if.sv
// Input channel: one source byte and its line-end flag.
interface ccsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

>>> src/ccsm_out_if.sv
// Output channel: one classified byte.
interface ccsm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_code;
  logic       eol;
  logic       last_of_run;

  modport source (output valid, output out_char, output is_code, output eol,
                  output last_of_run, input ready);
  modport sink (input valid, input out_char, input is_code, input eol,
                input last_of_run, output ready);
endinterface

>>> src/ccsm_front.sv
// Front end: accepts bytes, tracks lexical state and builds result entries.
module ccsm_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                ch_i,
  input  logic                      line_end_i,
  output logic                      push_o,
  output ccsm_pkg::entry_t          push_entry_o,
  input  logic                      push_ready_i,
  output ccsm_pkg::front_status_t   status_o
);

  typedef struct packed {
    logic             code;
    logic             eat;
    ccsm_pkg::modes_t modes;
  } dec_t;

  function automatic dec_t decide(input logic [7:0] c, input logic [7:0] nxt,
                                  input logic at_start, input logic [7:0] prev,
                                  input logic skip, input ccsm_pkg::modes_t m);
    dec_t r;
    r.code  = 1'b0;
    r.eat   = 1'b0;
    r.modes = m;
    if (skip || m.line) begin
      r.code = 1'b0;
    end else if (m.blk) begin
      if (c == ccsm_pkg::CharStar && nxt == ccsm_pkg::CharSlash) begin
        r.modes.blk = 1'b0;
        r.eat       = 1'b1;
      end
    end else if (m.str) begin
      if (c == ccsm_pkg::CharQuote && (at_start || prev != ccsm_pkg::CharBackslash)) begin
        r.modes.str = 1'b0;
      end
    end else if (c == ccsm_pkg::CharQuote) begin
      r.modes.str = 1'b1;
    end else if (c == ccsm_pkg::CharSlash && nxt == ccsm_pkg::CharSlash) begin
      r.modes.line = 1'b1;
      r.eat        = 1'b1;
    end else if (c == ccsm_pkg::CharSlash && nxt == ccsm_pkg::CharStar) begin
      r.modes.blk = 1'b1;
      r.eat       = 1'b1;
    end else begin
      r.code = 1'b1;
    end
    return r;
  endfunction

  logic             held_valid_q, held_valid_d;
  logic [7:0]       held_char_q, held_char_d;
  logic             held_skip_q, held_skip_d;
  logic             held_start_q, held_start_d;
  logic [7:0]       prior_q, prior_d;
  ccsm_pkg::modes_t modes_q, modes_d;

  dec_t             dec_held;
  dec_t             dec_cur;
  ccsm_pkg::modes_t modes_mid;
  logic             cur_skip;
  logic             cur_start;
  logic [7:0]       cur_prev;
  logic             accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    // The held byte is decided first; the incoming byte sees its effects.
    dec_held  = decide(held_char_q, ch_i, held_start_q, prior_q, held_skip_q, modes_q);
    modes_mid = held_valid_q ? dec_held.modes : modes_q;
    cur_skip  = held_valid_q && dec_held.eat;
    cur_start = !held_valid_q;
    cur_prev  = held_valid_q ? held_char_q : 8'h00;
    dec_cur   = decide(ch_i, ccsm_pkg::CharNone, cur_start, cur_prev, cur_skip, modes_mid);
  end

  always_comb begin
    push_o = accept && (held_valid_q || line_end_i);
    if (held_valid_q) begin
      push_entry_o.two = line_end_i;
      push_entry_o.r0  = '{out_char: held_char_q, is_code: dec_held.code, eol: 1'b0};
      push_entry_o.r1  = '{out_char: ch_i, is_code: dec_cur.code, eol: 1'b1};
    end else begin
      push_entry_o.two = 1'b0;
      push_entry_o.r0  = '{out_char: ch_i, is_code: dec_cur.code, eol: 1'b1};
      push_entry_o.r1  = '{out_char: ch_i, is_code: dec_cur.code, eol: 1'b1};
    end
  end

  always_comb begin
    held_valid_d = held_valid_q;
    held_char_d  = held_char_q;
    held_skip_d  = held_skip_q;
    held_start_d = held_start_q;
    prior_d      = prior_q;
    modes_d      = modes_q;
    if (accept) begin
      if (line_end_i) begin
        // Only block-comment state survives a line end.
        held_valid_d = 1'b0;
        held_char_d  = 8'h00;
        held_skip_d  = 1'b0;
        held_start_d = 1'b1;
        prior_d      = 8'h00;
        modes_d      = '{str: 1'b0, line: 1'b0, blk: dec_cur.modes.blk};
      end else begin
        held_valid_d = 1'b1;
        held_char_d  = ch_i;
        held_skip_d  = cur_skip;
        held_start_d = cur_start;
        prior_d      = cur_prev;
        modes_d      = modes_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_char_q  <= 8'h00;
      held_skip_q  <= 1'b0;
      held_start_q <= 1'b1;
      prior_q      <= 8'h00;
      modes_q      <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_char_q  <= held_char_d;
      held_skip_q  <= held_skip_d;
      held_start_q <= held_start_d;
      prior_q      <= prior_d;
      modes_q      <= modes_d;
    end
  end

  assign status_o = '{held_valid: held_valid_q, modes: modes_q};

endmodule

>>> src/ccsm_queue.sv
// Small FIFO of result entries between the front and back ends.
module ccsm_queue #(
  parameter int unsigned Depth = ccsm_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ccsm_pkg::entry_t push_entry_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output ccsm_pkg::entry_t head_entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ccsm_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign head_valid_o = count_q != '0;
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> src/ccsm_back.sv
// Back end: sends the one or two results of each queue entry in order.
module ccsm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  ccsm_pkg::entry_t head_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ccsm_pkg::result_t out_result_o,
  output logic             out_last_o
);

  logic sel_q, sel_d;
  logic xfer;

  assign out_valid_o  = head_valid_i;
  assign out_result_o = sel_q ? head_entry_i.r1 : head_entry_i.r0;
  assign out_last_o   = sel_q || !head_entry_i.two;
  assign xfer         = out_valid_o && out_ready_i;
  assign pop_o        = xfer && out_last_o;

  always_comb begin
    sel_d = sel_q;
    if (xfer) begin
      sel_d = !out_last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

>>> src/code_comment_string_masker.sv
// Top level of the code comment and string masker.
// Classifies a byte stream of source text as code or as string/comment content,
// one byte in per cycle. Each byte comes out one transfer later than it goes in,
// because its class depends on the next byte of the line; the last byte of a
// line releases itself and any held byte, so such an input causes one or two
// output transfers and the others zero or one. Input bytes are taken every
// cycle while the result queue (QueueDepth entries) has room; the output side
// moves one result per cycle while the receiver is ready, so sustained throughput is one byte per cycle,
// and the extra output transfer of a line-end byte is absorbed by the queue.
// The earliest result appears in the cycle after its input transfer.
`include "code_comment_string_masker_assert.svh"

module code_comment_string_masker #(
  parameter int unsigned QueueDepth = ccsm_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccsm_in_if.sink    in_i,
  ccsm_out_if.source out_o
);

  logic                    push;
  ccsm_pkg::entry_t        push_entry;
  logic                    push_ready;
  logic                    pop;
  logic                    head_valid;
  ccsm_pkg::entry_t        head_entry;
  ccsm_pkg::front_status_t status;
  ccsm_pkg::result_t       out_result;
  logic                    out_last;

  ccsm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .ch_i         (in_i.ch),
    .line_end_i   (in_i.line_end),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready),
    .status_o     (status)
  );

  ccsm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  ccsm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_result_o (out_result),
    .out_last_o   (out_last)
  );

  assign out_o.out_char    = out_result.out_char;
  assign out_o.is_code     = out_result.is_code;
  assign out_o.eol         = out_result.eol;
  assign out_o.last_of_run = out_last;

  // A line end leaves no held byte and no string or line-comment state.
  `CCSM_ASSERT(a_line_end_clears, in_i.valid && in_i.ready && in_i.line_end |=> !status.held_valid && !status.modes.str && !status.modes.line, "line end did not clear front state")
  // Any other accepted byte is held for lookahead.
  `CCSM_ASSERT(a_byte_held, in_i.valid && in_i.ready && !in_i.line_end |=> status.held_valid, "accepted byte was not held")
  // String, line comment and block comment exclude one another.
  `CCSM_ASSERT(a_modes_exclusive, $onehot0(status.modes), "more than one lexical mode active")
  // The second result of a pair is always available right after the first.
  `CCSM_ASSERT(a_pair_follows, out_o.valid && out_o.ready && !out_o.last_of_run |=> out_o.valid, "second result of a pair missing")

endmodule

>>> tb/sv/code_comment_string_masker_test.sv
// Testbench for the code comment and string masker: directed and random source text against a byte classifier.
`timescale 1ns / 100ps

module code_comment_string_masker_test;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned TextBytes  = 670;

  typedef struct {
    logic [7:0] ch;
    logic       line_end;
    logic       calm;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       code;
    logic       eol;
    logic       last;
  } masked_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ccsm_in_if  in_if ();
  ccsm_out_if out_if ();

  code_comment_string_masker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  text_byte_t   pending[$];
  masked_byte_t expected[$];
  int unsigned  bytes_in;
  int unsigned  text_total;
  int unsigned  mismatches;
  int unsigned  quiet_cycles;
  int unsigned  send_gap;
  int unsigned  recv_gap;
  logic         in_taken;
  logic         calm;
  logic         quiet_phase;

  // Classifier state, mirrored from the block's behavior.
  logic       have_held;
  logic [7:0] held_byte;
  logic       held_eaten;
  logic       held_first;
  logic [7:0] byte_before;
  logic       str_mode;
  logic       line_cmt;
  logic       blk_cmt;

  // Classifies one byte given its successor; eat marks the successor as the
  // second byte of a delimiter.
  function automatic logic judge(input logic [7:0] c, input logic [7:0] follow,
                                 input logic at_start, input logic [7:0] prev,
                                 input logic eaten, output logic eat);
    eat = 1'b0;
    if (eaten || line_cmt) return 1'b0;
    if (blk_cmt) begin
      if (c == ccsm_pkg::CharStar && follow == ccsm_pkg::CharSlash) begin
        blk_cmt = 1'b0;
        eat = 1'b1;
      end
      return 1'b0;
    end
    if (str_mode) begin
      if (c == ccsm_pkg::CharQuote && (at_start || prev != ccsm_pkg::CharBackslash)) begin
        str_mode = 1'b0;
      end
      return 1'b0;
    end
    if (c == ccsm_pkg::CharQuote) begin
      str_mode = 1'b1;
      return 1'b0;
    end
    if (c == ccsm_pkg::CharSlash && follow == ccsm_pkg::CharSlash) begin
      line_cmt = 1'b1;
      eat = 1'b1;
      return 1'b0;
    end
    if (c == ccsm_pkg::CharSlash && follow == ccsm_pkg::CharStar) begin
      blk_cmt = 1'b1;
      eat = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic classify_byte(input logic [7:0] c, input logic le);
    masked_byte_t got[2];
    int           n;
    logic         eat;
    logic         nxt_eaten;
    logic         nxt_first;
    logic [7:0]   nxt_prev;
    n = 0;
    nxt_eaten = 1'b0;
    nxt_first = 1'b1;
    nxt_prev = ccsm_pkg::CharNone;
    if (have_held) begin
      got[0].ch = held_byte;
      got[0].code = judge(held_byte, c, held_first, byte_before, held_eaten, eat);
      got[0].eol = 1'b0;
      got[0].last = 1'b0;
      n = 1;
      nxt_eaten = eat;
      nxt_first = 1'b0;
      nxt_prev = held_byte;
    end
    if (le) begin
      got[n].ch = c;
      got[n].code = judge(c, ccsm_pkg::CharNone, nxt_first, nxt_prev, nxt_eaten, eat);
      got[n].eol = 1'b1;
      got[n].last = 1'b0;
      n++;
      str_mode = 1'b0;
      line_cmt = 1'b0;
      have_held = 1'b0;
      held_byte = 8'h00;
      held_eaten = 1'b0;
      held_first = 1'b1;
      byte_before = 8'h00;
    end else begin
      have_held = 1'b1;
      held_byte = c;
      held_eaten = nxt_eaten;
      held_first = nxt_first;
      byte_before = nxt_prev;
    end
    if (n > 0) got[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected.push_back(got[i]);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // Monitor: records both channels at the rising edge.
  always @(posedge clk_i) begin : watch
    masked_byte_t want;
    logic         out_taken;
    in_taken = rst_ni && in_if.valid && in_if.ready;
    out_taken = rst_ni && out_if.valid && out_if.ready;
    if (in_taken) begin
      bytes_in++;
      classify_byte(in_if.ch, in_if.line_end);
    end
    if (out_taken) begin
      if (expected.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual char %02h", $time,
                 out_if.out_char);
        mismatches++;
      end else begin
        want = expected.pop_front();
        compare_field("out_char", want.ch, out_if.out_char);
        compare_field("is_code", {7'd0, want.code}, {7'd0, out_if.is_code});
        compare_field("eol", {7'd0, want.eol}, {7'd0, out_if.eol});
        compare_field("last_of_run", {7'd0, want.last}, {7'd0, out_if.last_of_run});
      end
    end
    if (rst_ni && !in_taken && !out_taken) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Driver and receiver: inputs change at the falling edge.
  always @(negedge clk_i) begin : drive
    text_byte_t item;
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_if.valid <= 1'b0;
        end else begin
          item = pending.pop_front();
          calm = item.calm;
          in_if.ch <= item.ch;
          in_if.line_end <= item.line_end;
          in_if.valid <= 1'b1;
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 3);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_byte(input logic [7:0] c, input logic le);
    text_byte_t item;
    item.ch = c;
    item.line_end = le;
    item.calm = quiet_phase;
    pending.push_back(item);
  endtask

  task automatic add_line(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endtask

  // Mostly delimiter-rich text, so comments and strings open and close often.
  function automatic logic [7:0] pick_char(input logic noisy);
    if (noisy) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1:    return ccsm_pkg::CharSlash;
      2:       return ccsm_pkg::CharStar;
      3:       return ccsm_pkg::CharQuote;
      4:       return ccsm_pkg::CharBackslash;
      5:       return 8'h20;
      9:       return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic add_random_line();
    int   len;
    logic noisy;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) add_byte(pick_char(noisy), i == len - 1);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch = 8'h00;
    in_if.line_end = 1'b0;
    out_if.ready = 1'b0;
    in_taken = 1'b0;
    calm = 1'b0;
    quiet_phase = 1'b0;
    bytes_in = 0;
    text_total = 0;
    mismatches = 0;
    quiet_cycles = 0;
    send_gap = 0;
    recv_gap = 0;
    have_held = 1'b0;
    held_byte = 8'h00;
    held_eaten = 1'b0;
    held_first = 1'b1;
    byte_before = 8'h00;
    str_mode = 1'b0;
    line_cmt = 1'b0;
    blk_cmt = 1'b0;

    // A one-byte line, an escaped quote inside a string, a line comment,
    // a block comment opened at the end of a line and carried over lines,
    // a star at line end that cannot close it, a lone slash at line end,
    // and NUL and all-ones bytes.
    add_line("x");
    add_line("\"a\\\"b\"");
    add_line("//c");
    add_line("a/*");
    add_line("q*");
    add_line("/b");
    add_line("*/");
    add_line("/");
    add_byte(8'hFF, 1'b0);
    add_byte(ccsm_pkg::CharNone, 1'b1);

    while (pending.size() < TextBytes) begin
      quiet_phase = (pending.size() >= 300 && pending.size() < 420) ||
                    pending.size() >= TextBytes - 100;
      add_random_line();
    end
    text_total = pending.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_in != text_total) @(negedge clk_i);
    while (expected.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/ccsm_pkg.sv
src/ccsm_in_if.sv
src/ccsm_out_if.sv
src/ccsm_front.sv
src/ccsm_queue.sv
src/ccsm_back.sv
src/code_comment_string_masker.sv
tb/sv/code_comment_string_masker_test.sv
